// File: src/server_health_backoff_table_top_assert.svh
// Assertion macros for the server health table.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SERVER_HEALTH_BACKOFF_TABLE_TOP_ASSERT_SVH
`define SERVER_HEALTH_BACKOFF_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SHBT_ASSERT_IMP(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHBT_ASSERT_NXT(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/shbt_pkg.sv
// Shared types, codes and constants of the server health table.
// No dependencies; used by shbt_update and the top level.
package shbt_pkg;

  localparam int NUM_SERVERS_DEFAULT = 16;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_TIMEOUT    = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADAPTIVE_ENABLE = 4'd1;

  localparam logic [15:0] BASE_TIMEOUT_RESET = 16'd1000;
  localparam logic        ADAPTIVE_RESET     = 1'b1;

  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [7:0]  STREAK_MAX = 8'hFF;
  localparam logic [7:0]  STREAK_MIN_BLOCK = 8'd3;
  localparam logic [7:0]  STREAK_8MIN      = 8'd4;

  // backoff windows in ms: 4, 8 and 16 minutes
  localparam logic [31:0] WINDOW_4MIN  = 32'd240000;
  localparam logic [31:0] WINDOW_8MIN  = 32'd480000;
  localparam logic [31:0] WINDOW_16MIN = 32'd960000;

  // floor(x/10) = (x * DIV10_MULT) >> DIV10_SHIFT, exact for x < 2^20
  localparam int          MIX_W       = 20;
  localparam logic [20:0] DIV10_MULT  = 21'd1677722;
  localparam int          DIV10_SHIFT = 24;

  typedef struct packed {
    logic [31:0] success_total;
    logic [31:0] failure_total;
    logic [7:0]  failure_streak;
    logic [15:0] avg_response_ms;
    logic [31:0] streak_start_ms;
  } entry_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        succeeded;
    logic [15:0] response_ms;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic        blacklisted;
    logic        known_server;
  } result_t;

endpackage

// File: src/shbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/shbt_update.sv
// Entry update and result logic for one command on one table entry.
// Depends on shbt_pkg.
module shbt_update (
  input  shbt_pkg::entry_t  cur,
  input  shbt_pkg::item_t   item,
  input  logic              known,
  input  logic [15:0]       timeout_base,
  input  logic              adaptive_enable,
  output shbt_pkg::entry_t  upd,
  output shbt_pkg::result_t res
);

  logic [shbt_pkg::MIX_W-1:0] mix;
  logic [40:0]                quot_prod;
  logic [15:0]                avg_mixed;
  logic [34:0]                s35;
  logic [34:0]                f35;
  logic                       any_history;
  logic                       rel_high;
  logic                       rel_low;
  logic [16:0]                twice_avg;
  logic [15:0]                capped;
  logic [31:0]                elapsed;
  logic [31:0]                window;

  assign mix = shbt_pkg::MIX_W'(cur.avg_response_ms) * shbt_pkg::MIX_W'(7)
             + shbt_pkg::MIX_W'(item.response_ms) * shbt_pkg::MIX_W'(3);
  assign quot_prod = 41'(mix) * 41'(shbt_pkg::DIV10_MULT);
  assign avg_mixed = quot_prod[shbt_pkg::DIV10_SHIFT +: 16];

  always_comb begin
    upd = cur;
    if (item.command == shbt_pkg::CMD_RECORD) begin
      if (item.succeeded) begin
        if (cur.success_total != shbt_pkg::COUNT_MAX) begin
          upd.success_total = cur.success_total + 32'd1;
        end
        upd.failure_streak = 8'd0;
        upd.avg_response_ms = (cur.avg_response_ms == 16'd0) ? item.response_ms : avg_mixed;
      end else begin
        if (cur.failure_total != shbt_pkg::COUNT_MAX) begin
          upd.failure_total = cur.failure_total + 32'd1;
        end
        if (cur.failure_streak != shbt_pkg::STREAK_MAX) begin
          upd.failure_streak = cur.failure_streak + 8'd1;
          if (cur.failure_streak == 8'd0) begin
            upd.streak_start_ms = item.now_ms;
          end
        end
      end
    end
  end

  // reliability by cross-multiplication: s > 4f, 7s < 3f
  assign s35 = 35'(upd.success_total);
  assign f35 = 35'(upd.failure_total);
  assign any_history = (upd.success_total != 32'd0) || (upd.failure_total != 32'd0);
  assign rel_high = any_history && (s35 > (f35 << 2));
  assign rel_low  = !any_history || (((s35 << 3) - s35) < ((f35 << 1) + f35));

  assign twice_avg = {upd.avg_response_ms, 1'b0};
  assign capped = (twice_avg < {1'b0, timeout_base}) ? twice_avg[15:0] : timeout_base;

  assign elapsed = item.now_ms - upd.streak_start_ms;

  always_comb begin
    case (upd.failure_streak)
      shbt_pkg::STREAK_MIN_BLOCK: window = shbt_pkg::WINDOW_4MIN;
      shbt_pkg::STREAK_8MIN:      window = shbt_pkg::WINDOW_8MIN;
      default:                    window = shbt_pkg::WINDOW_16MIN;
    endcase
  end

  always_comb begin
    if (!adaptive_enable || !known) begin
      res.timeout_ms = timeout_base;
    end else if (rel_high && upd.avg_response_ms != 16'd0) begin
      res.timeout_ms = capped;
    end else if (rel_low) begin
      res.timeout_ms = timeout_base >> 1;
    end else begin
      res.timeout_ms = timeout_base;
    end
    res.blacklisted = known && (upd.failure_streak >= shbt_pkg::STREAK_MIN_BLOCK)
                    && (elapsed < window);
    res.known_server = known;
  end

endmodule

// File: src/server_health_backoff_table_top.sv
// Server health table: each accepted input beat goes through the table read, then
// update and result register; one beat per cycle while the output is not stalled.
// The per-entry read-modify-write runs through the table RAM with a one-deep
// bypass for back-to-back beats on the same entry.
// Reset: synchronous, clears all entry valid bits at once (no clearing pass),
// base_timeout_ms to 1000 and adaptive_enable to 1.
module server_health_backoff_table_top #(
  parameter int NUM_SERVERS = shbt_pkg::NUM_SERVERS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic [3:0]                      server_index,
  input  logic [15:0]                     response_ms,
  input  logic                            succeeded,
  input  logic [31:0]                     now_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     timeout_ms,
  output logic                            blacklisted,
  output logic                            known_server,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [shbt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  `include "server_health_backoff_table_top_assert.svh"

  localparam int AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic [15:0]            timeout_base;
  logic                   adaptive_enable;
  logic [NUM_SERVERS-1:0] entry_valid;

  logic                   en;
  logic                   in_accept;
  logic [8:0]             in_idx_wide;
  logic [AW-1:0]          in_addr;

  logic                   s1_valid;
  shbt_pkg::item_t        s1_item;
  logic [AW-1:0]          s1_addr;
  logic                   s1_in_range;

  shbt_pkg::entry_t       ram_rdata;
  shbt_pkg::entry_t       src_entry;
  shbt_pkg::entry_t       cur_entry;
  shbt_pkg::entry_t       upd_entry;
  shbt_pkg::result_t      res;
  logic                   is_record;
  logic                   is_clear;
  logic                   known;
  logic                   wr_en;

  logic                   fwd_valid;
  logic [AW-1:0]          fwd_addr;
  shbt_pkg::entry_t       fwd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_base <= shbt_pkg::BASE_TIMEOUT_RESET;
      adaptive_enable <= shbt_pkg::ADAPTIVE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        shbt_pkg::REG_BASE_TIMEOUT:    timeout_base <= cfg_data;
        shbt_pkg::REG_ADAPTIVE_ENABLE: adaptive_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign in_accept = in_valid && en;
  assign in_idx_wide = {5'd0, server_index};
  assign in_addr = in_idx_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= '{command: command, succeeded: succeeded,
                   response_ms: response_ms, now_ms: now_ms};
      s1_addr <= in_addr;
      s1_in_range <= in_idx_wide < 9'(NUM_SERVERS);
    end
  end

  shbt_ram #(
    .WIDTH ($bits(shbt_pkg::entry_t)),
    .DEPTH (NUM_SERVERS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (upd_entry),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign is_record = s1_item.command == shbt_pkg::CMD_RECORD;
  assign is_clear  = s1_item.command == shbt_pkg::CMD_CLEAR;
  assign src_entry = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
  assign cur_entry = (s1_in_range && entry_valid[s1_addr]) ? src_entry : '0;
  assign known = s1_in_range && !is_clear && (entry_valid[s1_addr] || is_record);
  assign wr_en = en && s1_valid && s1_in_range && is_record;

  shbt_update u_update (
    .cur             (cur_entry),
    .item            (s1_item),
    .known           (known),
    .timeout_base    (timeout_base),
    .adaptive_enable (adaptive_enable),
    .upd             (upd_entry),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (en) begin
      fwd_valid <= wr_en;
      if (s1_valid && is_clear) begin
        entry_valid <= '0;
      end else if (wr_en) begin
        entry_valid[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_addr <= s1_addr;
      fwd_data <= upd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      timeout_ms <= res.timeout_ms;
      blacklisted <= res.blacklisted;
      known_server <= res.known_server;
    end
  end

  `SHBT_ASSERT_NXT(a_s1_held, clk, rst, s1_valid && !en, s1_valid && $stable(s1_item), "s1")
  `SHBT_ASSERT_NXT(a_clear_empties, clk, rst, en && s1_valid && is_clear, entry_valid == '0, "clr")
  `SHBT_ASSERT_NXT(a_record_marks, clk, rst, wr_en, entry_valid[$past(s1_addr)], "mark")
  `SHBT_ASSERT_IMP(a_black_known, clk, rst, out_valid && blacklisted, known_server, "black")

endmodule

// File: tb/sv/tb_server_health_backoff_table_top.sv
// Self-checking testbench for server_health_backoff_table_top. Needs shbt_pkg.
// A directed table, then random phases with config changes, idling and a long
// output hold; results are checked against typed rows or a local predictor.
module tb_server_health_backoff_table_top;
  import shbt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned TABLE_SIZE     = 16;
  localparam logic [31:0] MINUTE_MS      = 32'd60000;
  localparam logic [31:0] T_WRAP         = 32'hFFFF_FFF0;
  localparam logic [7:0]  LONG_STREAK    = 8'd5;
  localparam logic [31:0] MAX_BACKOFF    = 32'd16;
  localparam logic [1:0]  CMD_SPARE      = 2'd3;

  typedef struct {
    logic [1:0]  command;
    logic [3:0]  idx;
    logic [15:0] resp;
    logic        ok;
    logic [31:0] now;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_QUERY;
  logic [3:0]  server_index = '0;
  logic [15:0] response_ms = '0;
  logic        succeeded = 1'b0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] timeout_ms;
  logic        blacklisted;
  logic        known_server;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state
  bit        ent_valid [TABLE_SIZE];
  bit [31:0] succ_cnt  [TABLE_SIZE];
  bit [31:0] fail_cnt  [TABLE_SIZE];
  bit [7:0]  streak    [TABLE_SIZE];
  bit [15:0] avg_ms    [TABLE_SIZE];
  bit [31:0] streak_t0 [TABLE_SIZE];
  bit [15:0] base_to  = BASE_TIMEOUT_RESET;
  bit        adapt_on = ADAPTIVE_RESET;

  result_t     health_due [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] wall_ms = 32'd0;
  result_t     head;

  server_health_backoff_table_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .server_index(server_index), .response_ms(response_ms),
    .succeeded(succeeded), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .timeout_ms(timeout_ms), .blacklisted(blacklisted), .known_server(known_server),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic result_t apply_health_cmd(logic [1:0] cmd, logic [3:0] idx,
                                               logic [15:0] resp, logic ok, logic [31:0] now);
    result_t   r;
    bit [63:0] s;
    bit [63:0] f;
    bit [16:0] twice;
    bit [31:0] mins;
    bit [31:0] win;
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        ent_valid[i] = 1'b0;
        succ_cnt[i]  = '0;
        fail_cnt[i]  = '0;
        streak[i]    = '0;
        avg_ms[i]    = '0;
        streak_t0[i] = '0;
      end
    end else if (cmd == CMD_RECORD) begin
      ent_valid[idx] = 1'b1;
      if (ok) begin
        if (succ_cnt[idx] != COUNT_MAX) succ_cnt[idx]++;
        streak[idx] = '0;
        if (avg_ms[idx] == 0) begin
          avg_ms[idx] = resp;
        end else begin
          avg_ms[idx] = 16'((32'(avg_ms[idx]) * 7 + 32'(resp) * 3) / 10);
        end
      end else begin
        if (fail_cnt[idx] != COUNT_MAX) fail_cnt[idx]++;
        if (streak[idx] != STREAK_MAX) begin
          streak[idx]++;
          if (streak[idx] == 8'd1) streak_t0[idx] = now;
        end
      end
    end
    r.timeout_ms   = base_to;
    r.blacklisted  = 1'b0;
    r.known_server = ent_valid[idx];
    if (adapt_on && ent_valid[idx]) begin
      s = succ_cnt[idx];
      f = fail_cnt[idx];
      twice = {avg_ms[idx], 1'b0};
      if (s + f != 0 && s > 4 * f && avg_ms[idx] != 0) begin
        r.timeout_ms = (twice < {1'b0, base_to}) ? twice[15:0] : base_to;
      end else if (s + f == 0 || 7 * s < 3 * f) begin
        r.timeout_ms = base_to >> 1;
      end
    end
    if (ent_valid[idx] && streak[idx] >= STREAK_MIN_BLOCK) begin
      win  = (streak[idx] >= LONG_STREAK) ? MAX_BACKOFF : (32'd1 << (streak[idx] - 1));
      mins = (now - streak_t0[idx]) / MINUTE_MS;
      r.blacklisted = (mins < win);
    end
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] c, logic [3:0] i, logic [15:0] rs, logic ok,
                                       logic [31:0] t, bit typed, logic [15:0] to, logic bl,
                                       logic kn);
    stim_row_t row;
    row.command = c;
    row.idx     = i;
    row.resp    = rs;
    row.ok      = ok;
    row.now     = t;
    row.typed   = typed;
    row.want.timeout_ms   = to;
    row.want.blacklisted  = bl;
    row.want.known_server = kn;
    return row;
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic [3:0] idx, input logic [15:0] resp,
                           input logic ok, input logic [31:0] now, input bit typed,
                           input result_t want);
    result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    command      <= cmd;
    server_index <= idx;
    response_ms  <= resp;
    succeeded    <= ok;
    now_ms       <= now;
    do @(posedge clk); while (in_stall);
    got = apply_health_cmd(cmd, idx, resp, ok, now);
    health_due.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (health_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] ri, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (ri == REG_BASE_TIMEOUT) base_to = val;
    else if (ri == REG_ADAPTIVE_ENABLE) adapt_on = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_burst();
    int unsigned pick;
    int unsigned n;
    logic [3:0]  idx;
    logic [15:0] resp;
    pick = $urandom_range(99);
    idx  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    if (pick < 40) begin
      // failure streak, then look at it across the backoff windows
      n = $urandom_range(1, 7);
      repeat (n) begin
        wall_ms += $urandom_range(0, 20000);
        send_beat(CMD_RECORD, idx, 16'($urandom), 1'b0, wall_ms, 1'b0, '0);
      end
      n = $urandom_range(1, 3);
      repeat (n) begin
        wall_ms += $urandom_range(0, 1100000);
        send_beat(CMD_QUERY, idx, 16'($urandom), 1'($urandom), wall_ms, 1'b0, '0);
      end
    end else if (pick < 75) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        wall_ms += $urandom_range(0, 5000);
        resp = ($urandom_range(3) != 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
        send_beat(CMD_RECORD, idx, resp, ($urandom_range(4) != 0), wall_ms, 1'b0, '0);
      end
    end else if (pick < 90) begin
      wall_ms += $urandom_range(0, 300000);
      send_beat(($urandom_range(3) == 0) ? CMD_SPARE : CMD_QUERY, idx, 16'($urandom),
                1'($urandom), wall_ms, 1'b0, '0);
    end else if (pick < 93) begin
      send_beat(CMD_CLEAR, 4'($urandom), 16'($urandom), 1'($urandom), wall_ms, 1'b0, '0);
    end else begin
      send_beat(2'($urandom), 4'($urandom), 16'($urandom), 1'($urandom), $urandom, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [15:0] base, input logic adapt, input int unsigned idle_pct,
                           input int unsigned hold_pct, input bit squeeze,
                           input int unsigned count);
    int unsigned target;
    settle_block();
    write_reg(REG_BASE_TIMEOUT, base);
    write_reg(REG_ADAPTIVE_ENABLE, {15'd0, adapt});
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    if (squeeze) hold_left = 300;
    wall_ms = $urandom;
    target = items_sent + count;
    while (items_sent < target) random_burst();
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t %s: expected timeout=%0d blacklisted=%0b known=%0b, got timeout=%0d blacklisted=%0b known=%0b",
               $realtime, what, want.timeout_ms, want.blacklisted, want.known_server,
               got.timeout_ms, got.blacklisted, got.known_server);
    end
    mismatch_count++;
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (health_due.size() == 0) begin
        note_mismatch("result beat with none pending", '0,
                      '{timeout_ms, blacklisted, known_server});
      end else begin
        head = health_due.pop_front();
        if (head.timeout_ms !== timeout_ms || head.blacklisted !== blacklisted ||
            head.known_server !== known_server) begin
          note_mismatch("result mismatch", head, '{timeout_ms, blacklisted, known_server});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t plan [$];
    stim_row_t row;
    plan.push_back(mk_row(CMD_QUERY,  4'd0,  16'd0,      1'b0, 32'd0,        1, 16'd1000, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd0,  16'd100,    1'b1, 32'd1000,     1, 16'd200,  0, 1));
    plan.push_back(mk_row(CMD_RECORD, 4'd0,  16'hFFFF,   1'b1, 32'd2000,     0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'hFFFF,   1'b0, T_WRAP,       1, 16'd500,  0, 1));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'd0,      1'b0, 32'hFFFF_FFFF, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'd7,      1'b0, 32'd5,        0, '0, 0, 0));
    plan.push_back(mk_row(CMD_QUERY,  4'd15, 16'd0,      1'b0, T_WRAP + 4 * MINUTE_MS - 1, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_QUERY,  4'd15, 16'd0,      1'b0, T_WRAP + 4 * MINUTE_MS, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'd0,      1'b0, T_WRAP + 4 * MINUTE_MS, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_QUERY,  4'd15, 16'd0,      1'b0, T_WRAP + 8 * MINUTE_MS, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'd0,      1'b0, T_WRAP + 8 * MINUTE_MS, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'd0,      1'b0, T_WRAP + 9 * MINUTE_MS, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_QUERY,  4'd15, 16'd0,      1'b0, T_WRAP + 16 * MINUTE_MS - 1, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_QUERY,  4'd15, 16'd0,      1'b0, T_WRAP + 16 * MINUTE_MS, 0, '0, 0, 0));
    plan.push_back(mk_row(CMD_SPARE,  4'd15, 16'hFFFF,   1'b1, T_WRAP + 1,   0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'd0,      1'b1, 32'd0,        0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd15, 16'd2000,   1'b1, 32'd10,       0, '0, 0, 0));
    plan.push_back(mk_row(CMD_CLEAR,  4'd7,  16'hFFFF,   1'b1, 32'hFFFF_FFFF, 1, 16'd1000, 0, 0));
    plan.push_back(mk_row(CMD_QUERY,  4'd15, 16'd0,      1'b0, 32'd20,       1, 16'd1000, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd7,  16'd0,      1'b1, 32'hFFFF_FFFF, 1, 16'd1000, 0, 1));
    plan.push_back(mk_row(CMD_RECORD, 4'd7,  16'hFFFF,   1'b0, 32'd0,        0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd7,  16'd300,    1'b1, 32'd100,      0, '0, 0, 0));
    plan.push_back(mk_row(CMD_RECORD, 4'd8,  16'h5555,   1'b0, 32'hAAAA_AAAA, 1, 16'd500, 0, 1));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      row = plan[k];
      send_beat(row.command, row.idx, row.resp, row.ok, row.now, row.typed, row.want);
    end

    run_phase(BASE_TIMEOUT_RESET, 1'b1, 0, 0, 1'b0, 240);

    // drive one streak into saturation; its start time must hold
    wall_ms = $urandom;
    for (int n = 0; n < 258; n++) begin
      wall_ms += $urandom_range(0, 2000);
      send_beat(CMD_RECORD, 4'd9, 16'($urandom), 1'b0, wall_ms, 1'b0, '0);
    end
    wall_ms += $urandom_range(0, 1100000);
    send_beat(CMD_QUERY, 4'd9, 16'($urandom), 1'b0, wall_ms, 1'b0, '0);

    run_phase(16'd60000, 1'b1, 56, 0, 1'b0, 230);
    run_phase(16'd0, 1'b1, 0, 56, 1'b1, 230);
    run_phase(16'hFFFF, 1'b0, 14, 14, 1'b0, 230);
    run_phase(16'($urandom_range(200, 5000)), 1'b1, 0, 0, 1'b0, 230);
    run_phase(16'hFFFF, 1'b1, 14, 14, 1'b0, 100);

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && health_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
